[src/fqs_pkg.sv]
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types and constants for the FIFO queue with linear search.
// ----------------------------------------------------------------------------
package fqs_pkg;

   localparam int DATA_W    = 32;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int DIST_W    = 4;
   localparam int FILL_W    = 5;
   localparam int DEPTH_DEF = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_SEARCH = 2'd2
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_req;
      logic       push_write;
      logic       pop_commit;
      logic       search_start;
      logic       search_step;
      logic       set_status;
      status_type status_code;
      logic       set_dist;
      logic       result_load;
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             full;
      logic             empty;
      logic             match;
      logic             last;
      logic             out_free;
   } stat_type;

endpackage

[src/fqs_datapath.sv]
// ----------------------------------------------------------------------------
// fqs_datapath
// Entry store, head/tail pointers, count, search walker and result register.
// ----------------------------------------------------------------------------
module fqs_datapath #(
   parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [fqs_pkg::CMD_W-1:0]           req_command,
   input  logic signed [fqs_pkg::DATA_W-1:0]   req_value,
   input  fqs_pkg::ctrl_type                   ctrl,
   output fqs_pkg::stat_type                   stat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fqs_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [fqs_pkg::DATA_W-1:0]   rsp_popped_value,
   output logic [fqs_pkg::DIST_W-1:0]          rsp_distance,
   output logic signed [fqs_pkg::DATA_W-1:0]   rsp_head_value,
   output logic                                rsp_is_empty,
   output logic [fqs_pkg::FILL_W-1:0]          rsp_fill_count
);
   import fqs_pkg::*;

   localparam int IDXW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   function automatic logic [IDXW-1:0] next_idx(input logic [IDXW-1:0] i);
      return (i == IDXW'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [IDXW-1:0]   rd_addr;

   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [IDXW-1:0]   head_ff, head_in;
   logic [IDXW-1:0]   tail_ff, tail_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic [IDXW-1:0]   sidx_ff, sidx_in;
   logic [IDXW-1:0]   k_ff, k_in;
   status_type        status_ff, status_in;
   logic [DATA_W-1:0] popped_ff, popped_in;
   logic [IDXW-1:0]   dist_ff, dist_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_popped_ff, rsp_popped_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic [DATA_W-1:0]   rsp_head_ff, rsp_head_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic [FILL_W-1:0]   rsp_fill_ff, rsp_fill_in;

   // single read port: the walker address on a search step, else the head
   assign rd_addr = ctrl.search_step ? sidx_ff : head_ff;

   always_ff @(posedge clock) begin
      if (ctrl.push_write) begin
         store_ff[tail_ff] <= val_ff;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   always_comb begin
      cmd_in    = cmd_ff;
      val_in    = val_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      sidx_in   = sidx_ff;
      k_in      = k_ff;
      status_in = status_ff;
      popped_in = popped_ff;
      dist_in   = dist_ff;

      if (ctrl.load_req) begin
         cmd_in    = req_command;
         val_in    = req_value;
         status_in = ST_OK;
         popped_in = '0;
         dist_in   = '0;
      end
      if (ctrl.push_write) begin
         tail_in  = next_idx(tail_ff);
         count_in = count_ff + 1'b1;
      end
      if (ctrl.pop_commit) begin
         popped_in = rd_data_ff;
         head_in   = next_idx(head_ff);
         count_in  = count_ff - 1'b1;
      end
      if (ctrl.search_start) begin
         sidx_in = next_idx(head_ff);
         k_in    = '0;
      end
      if (ctrl.search_step) begin
         sidx_in = next_idx(sidx_ff);
         k_in    = k_ff + 1'b1;
      end
      if (ctrl.set_status) begin
         status_in = ctrl.status_code;
      end
      if (ctrl.set_dist) begin
         dist_in = k_ff;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_fill_in   = rsp_fill_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.result_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_popped_in = popped_ff;
         rsp_dist_in   = DIST_W'(dist_ff);
         rsp_head_in   = (count_ff == '0) ? '0 : rd_data_ff;
         rsp_empty_in  = (count_ff == '0);
         rsp_fill_in   = FILL_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      sidx_ff       <= sidx_in;
      k_ff          <= k_in;
      status_ff     <= status_in;
      popped_ff     <= popped_in;
      dist_ff       <= dist_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   always_comb begin
      stat.command  = cmd_ff;
      stat.full     = (count_ff == CNTW'(DEPTH));
      stat.empty    = (count_ff == '0);
      stat.match    = (rd_data_ff == val_ff);
      stat.last     = ((CNTW'(k_ff) + CNTW'(1)) == count_ff);
      stat.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_distance     = rsp_dist_ff;
   assign rsp_head_value   = rsp_head_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_fill_count   = rsp_fill_ff;

endmodule

[src/fqs_ctrl.sv]
// ----------------------------------------------------------------------------
// fqs_ctrl
// Command sequencer: issues store accesses and the search walk step by step.
// ----------------------------------------------------------------------------
module fqs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fqs_pkg::stat_type stat,
   output fqs_pkg::ctrl_type ctrl
);
   import fqs_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE      = 6'b000001,
      S_EXEC      = 6'b000010,
      S_POP_WAIT  = 6'b000100,
      S_SEARCH    = 6'b001000,
      S_HEAD_RD   = 6'b010000,
      S_HEAD_WAIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load_req = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_HEAD_RD;
            case (stat.command)
               CMD_PUSH: begin
                  if (stat.full) begin
                     ctrl.set_status  = 1'b1;
                     ctrl.status_code = ST_FULL;
                  end else begin
                     ctrl.push_write = 1'b1;
                  end
               end
               CMD_POP: begin
                  if (stat.empty) begin
                     ctrl.set_status  = 1'b1;
                     ctrl.status_code = ST_EMPTY;
                  end else begin
                     state_in = S_POP_WAIT;   // head entry read in flight
                  end
               end
               CMD_SEARCH: begin
                  if (stat.empty) begin
                     ctrl.set_status  = 1'b1;
                     ctrl.status_code = ST_NOT_FOUND;
                  end else begin
                     ctrl.search_start = 1'b1;
                     state_in          = S_SEARCH;
                  end
               end
               default: begin
               end
            endcase
         end
         S_POP_WAIT: begin
            ctrl.pop_commit = 1'b1;
            state_in        = S_HEAD_RD;
         end
         S_SEARCH: begin
            // compare entry k; if it neither matches nor is last, issue the read of entry k+1
            if (stat.match) begin
               ctrl.set_dist = 1'b1;
               state_in      = S_HEAD_RD;
            end else if (stat.last) begin
               ctrl.set_status  = 1'b1;
               ctrl.status_code = ST_NOT_FOUND;
               state_in         = S_HEAD_RD;
            end else begin
               ctrl.search_step = 1'b1;
            end
         end
         S_HEAD_RD: begin
            state_in = S_HEAD_WAIT;
         end
         S_HEAD_WAIT: begin
            if (stat.out_free) begin
               ctrl.result_load = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/fifo_queue_with_search.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// Bounded FIFO of signed 32-bit values with push, pop and linear search.
// ----------------------------------------------------------------------------
// One command is in work at a time; every command returns one result that
// also reports the head value, empty flag and fill count after the command.
// From acceptance to the result being registered, push, the unused command
// code and commands that fail at once pass S_EXEC, S_HEAD_RD and S_HEAD_WAIT;
// pop adds S_POP_WAIT, and a search on a non-empty queue stays in S_SEARCH
// for each entry compared. The search rate is set by the entry store's single
// read port, walked one entry per cycle from the head. The result sits in an
// output register, so the next command is accepted while it waits.
// ----------------------------------------------------------------------------
module fifo_queue_with_search #(
   parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fqs_pkg::CMD_W-1:0]           req_command,
   input  logic signed [fqs_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fqs_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [fqs_pkg::DATA_W-1:0]   rsp_popped_value,
   output logic [fqs_pkg::DIST_W-1:0]          rsp_distance,
   output logic signed [fqs_pkg::DATA_W-1:0]   rsp_head_value,
   output logic                                rsp_is_empty,
   output logic [fqs_pkg::FILL_W-1:0]          rsp_fill_count
);
   import fqs_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   fqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   fqs_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_value        (req_value),
      .ctrl             (ctrl),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_distance     (rsp_distance),
      .rsp_head_value   (rsp_head_value),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_fill_count   (rsp_fill_count)
   );

endmodule

[tb/tb_fifo_queue_with_search.sv]
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_search
// Self-checking testbench for the FIFO queue with linear search: a short
// directed sequence through the empty, full, wrap and miss cases, then
// biased random fill/drain/mixed phases with random idling on both sides.
// A queue-based mirror predicts every response, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_fifo_queue_with_search;
   timeunit 1ns;
   timeprecision 1ps;

   import fqs_pkg::*;

   localparam int DEPTH = DEPTH_DEF;
   localparam int RANDOM_ITEMS = 400;
   // command code with no function: the queue only reports its state
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] popped;
      logic [DIST_W-1:0]        distance;
      logic signed [DATA_W-1:0] head;
      logic                     is_empty;
      logic [FILL_W-1:0]        fill;
   } queue_result_type;

   class queue_scoreboard;
      logic signed [DATA_W-1:0] held_values[$];
      queue_result_type         expected_results[$];
      int                       mismatches = 0;

      function int pending();
         return expected_results.size();
      endfunction

      // mirror one accepted command and queue the response it must produce
      function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val);
         queue_result_type r;
         r.status   = ST_OK;
         r.popped   = '0;
         r.distance = '0;
         case (cmd)
            CMD_PUSH: begin
               if (held_values.size() >= DEPTH) r.status = ST_FULL;
               else held_values.push_back(val);
            end
            CMD_POP: begin
               if (held_values.size() == 0) r.status = ST_EMPTY;
               else r.popped = held_values.pop_front();
            end
            CMD_SEARCH: begin
               r.status = ST_NOT_FOUND;
               for (int k = 0; k < held_values.size(); k++) begin
                  if (held_values[k] == val) begin
                     r.status   = ST_OK;
                     r.distance = DIST_W'(k);
                     break;
                  end
               end
            end
            default: ;
         endcase
         r.is_empty = (held_values.size() == 0);
         r.head     = r.is_empty ? '0 : held_values[0];
         r.fill     = FILL_W'(held_values.size());
         expected_results.push_back(r);
      endfunction

      task report_mismatch(string what, logic [63:0] got_v, logic [63:0] exp_v);
         $display("%0t ns: mismatch %s: got %0h expected %0h", $time, what, got_v, exp_v);
         mismatches++;
      endtask

      task check_response(queue_result_type got);
         queue_result_type exp;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", got.status, 0);
            return;
         end
         exp = expected_results.pop_front();
         if (got.status !== exp.status) report_mismatch("status", got.status, exp.status);
         if (got.popped !== exp.popped) report_mismatch("popped_value", got.popped, exp.popped);
         if (got.distance !== exp.distance) report_mismatch("distance", got.distance, exp.distance);
         if (got.head !== exp.head) report_mismatch("head_value", got.head, exp.head);
         if (got.is_empty !== exp.is_empty)
            report_mismatch("is_empty", got.is_empty, exp.is_empty);
         if (got.fill !== exp.fill) report_mismatch("fill_count", got.fill, exp.fill);
      endtask

      task check_leftover();
         if (expected_results.size() != 0)
            report_mismatch("responses never returned", expected_results.size(), 0);
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_popped_value;
   logic [DIST_W-1:0]        rsp_distance;
   logic signed [DATA_W-1:0] rsp_head_value;
   logic                     rsp_is_empty;
   logic [FILL_W-1:0]        rsp_fill_count;

   queue_scoreboard  sb = new;
   queue_result_type observed;
   int               gap_pct = 0;
   int               stall_pct = 0;
   int               hold_request = 0;

   fifo_queue_with_search #(.DEPTH(DEPTH)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_distance     (rsp_distance),
      .rsp_head_value   (rsp_head_value),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_fill_count   (rsp_fill_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // response side: random stall bursts, plus a long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         observed.status   = status_type'(rsp_status);
         observed.popped   = rsp_popped_value;
         observed.distance = rsp_distance;
         observed.head     = rsp_head_value;
         observed.is_empty = rsp_is_empty;
         observed.fill     = rsp_fill_count;
         sb.check_response(observed);
      end
   end

   task automatic send_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [DATA_W-1:0] val);
      int gap;
      gap = (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 19) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= val;
      do @(posedge clock); while (req_stall);
      sb.note_command(cmd, val);
   endtask

   // sender goes quiet until every outstanding response has been returned
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(0, 3))
         0: return int'($urandom_range(0, 15)) - 8;
         1: begin
            case ($urandom_range(0, 3))
               0: return VAL_MIN;
               1: return VAL_MAX;
               2: return '0;
               default: return -1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random(traffic_mode_type mode);
      int                       pick;
      int                       push_lim;
      int                       pop_lim;
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] val;
      push_lim = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 20 : 40;
      pop_lim  = (mode == MODE_FILL) ? 80 : 70;
      pick = $urandom_range(0, 99);
      if (pick < push_lim) cmd = CMD_PUSH;
      else if (pick < pop_lim) cmd = CMD_POP;
      else if (pick < 97) cmd = CMD_SEARCH;
      else cmd = CMD_UNUSED;
      val = random_value();
      // most searches look for something that is actually held
      if (cmd == CMD_SEARCH && sb.held_values.size() != 0 && $urandom_range(0, 3) != 0)
         val = sb.held_values[$urandom_range(0, sb.held_values.size() - 1)];
      send_command(cmd, val);
   endtask

   initial begin
      int               sent;
      int               phase;
      int               phase_len;
      int               drain_cycles;
      traffic_mode_type mode;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = CMD_PUSH;
      req_value   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue corner cases, then extreme values pushed, searched and popped
      send_command(CMD_POP, 0);
      send_command(CMD_SEARCH, 0);
      send_command(CMD_UNUSED, 32'sh1234_5678);
      send_command(CMD_PUSH, VAL_MIN);
      send_command(CMD_PUSH, VAL_MAX);
      send_command(CMD_SEARCH, VAL_MAX);
      send_command(CMD_SEARCH, VAL_MIN);
      send_command(CMD_SEARCH, -1);
      send_command(CMD_UNUSED, -1);
      send_command(CMD_POP, 0);
      send_command(CMD_POP, 0);
      send_command(CMD_POP, 0);
      // fill to the brim, overflow, then wrap the tail
      for (int i = 0; i < DEPTH; i++)
         send_command(CMD_PUSH, (i % 2) ? (32'shAAAA_AAAA ^ i) : (32'sh5555_5555 ^ i));
      send_command(CMD_PUSH, 0);
      send_command(CMD_SEARCH, 32'shAAAA_AAAA ^ (DEPTH - 1));
      send_command(CMD_POP, 0);
      send_command(CMD_PUSH, VAL_MAX);
      send_command(CMD_SEARCH, VAL_MAX);

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(20, 60);
         if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
         mode = traffic_mode_type'($urandom_range(0, 2));
         if (RANDOM_ITEMS - sent <= 60) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         end
         if (phase == 3) begin
            // receiver backs off while we keep offering transfers
            gap_pct      = 0;
            mode         = MODE_FILL;
            hold_request = 400;
         end
         if (phase == 5) wait_drained();
         repeat (phase_len) begin
            send_random(mode);
            sent++;
         end
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      drain_cycles = 0;
      while (sb.pending() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (DEPTH + 10) @(posedge clock);
      sb.check_leftover();
      if (sb.mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

[filelist.f]
src/fqs_pkg.sv
src/fqs_datapath.sv
src/fqs_ctrl.sv
src/fifo_queue_with_search.sv
tb/tb_fifo_queue_with_search.sv
